@@ hw/rtl/jbhd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbhd_pkg
// shared types, constants and helpers for the jpeg block huffman decoder
// ----------------------------------------------------------------------------
package jbhd_pkg;

    localparam int DC_TABLE_DEPTH_DEF = 16;
    localparam int AC_TABLE_DEPTH_DEF = 256;
    localparam int BLOCK_COEFFS_DEF   = 64;
    localparam int MAX_CODE_BITS_DEF  = 16;

    localparam int ENTRY_W = 29;

    localparam logic [1:0] OP_LOAD_DC = 2'd0;
    localparam logic [1:0] OP_LOAD_AC = 2'd1;
    localparam logic [1:0] OP_DATA    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic       REG_DC_COUNT = 1'b0;
    localparam logic       REG_AC_COUNT = 1'b1;

    localparam logic [7:0] SYM_EOB = 8'h00;
    localparam logic [7:0] MAG_MAX = 8'h0F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_DC_CODE = 2'd0,
        PH_DC_BITS = 2'd1,
        PH_AC_CODE = 2'd2,
        PH_AC_BITS = 2'd3
    } phase_t;

    function automatic logic [15:0] mag_to_value(input logic [3:0] mag, input logic [14:0] vb);
        logic [15:0] mask;
        logic [15:0] v;
        mask = (16'd1 << mag) - 16'd1;
        v    = {1'b0, vb} & mask;
        if (mag == 4'd0)
            return 16'd0;
        else if (v[mag - 4'd1])
            return v;
        else
            return v - mask;
    endfunction

endpackage

@@ hw/rtl/jpeg_block_huffman_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_block_huffman_decoder
// baseline jpeg 8x8 block coefficient decoder, one compressed bit per item
// ----------------------------------------------------------------------------
// channels: input items (table loads and data bits) on in_valid/in_ready,
// coefficient results on out_valid/out_ready, and register writes on
// cfg_valid/cfg_ready (index 0 dc entry count, 1 ac entry count).
// a code bit starts a scan of the active table, held in a synchronous
// memory: each slot is read, then compared, and the scan stops at the first
// match; a miss scans all valid entries before the bit is done.
// results leave through an output register at one per cycle while out_ready
// is high; an end of block gives up to 63 of them in a row. a new item is
// taken once all results of the previous one are in the output register.
// when the receiver stalls, the block holds its current result and waits.
// reset clears the decode state and the entry counts; table contents are
// undefined until loaded. errors give a single result with error and
// last_in_block set, and the decoder rearms for a new block.
// ----------------------------------------------------------------------------
module jpeg_block_huffman_decoder #(
    parameter int DC_TABLE_DEPTH = jbhd_pkg::DC_TABLE_DEPTH_DEF,
    parameter int AC_TABLE_DEPTH = jbhd_pkg::AC_TABLE_DEPTH_DEF,
    parameter int BLOCK_COEFFS   = jbhd_pkg::BLOCK_COEFFS_DEF,
    parameter int MAX_CODE_BITS  = jbhd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [7:0]         entry_index,
    input  logic [4:0]         code_length,
    input  logic [15:0]        code_bits,
    input  logic [7:0]         symbol,
    input  logic               data_bit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] coefficient,
    output logic [5:0]         coeff_index,
    output logic               last_in_block,
    output logic               error
);

    localparam int DCAW = (DC_TABLE_DEPTH > 1) ? $clog2(DC_TABLE_DEPTH) : 1;
    localparam int ACAW = (AC_TABLE_DEPTH > 1) ? $clog2(AC_TABLE_DEPTH) : 1;
    localparam logic [8:0] DC_DEPTH_V = 9'(DC_TABLE_DEPTH);
    localparam logic [8:0] AC_DEPTH_V = 9'(AC_TABLE_DEPTH);
    localparam logic [6:0] LAST_IDX   = 7'(BLOCK_COEFFS - 1);
    localparam logic [4:0] MAX_LEN    = 5'(MAX_CODE_BITS);

    logic [jbhd_pkg::ENTRY_W-1:0] dc_mem [DC_TABLE_DEPTH];
    logic [jbhd_pkg::ENTRY_W-1:0] ac_mem [AC_TABLE_DEPTH];
    logic [jbhd_pkg::ENTRY_W-1:0] dc_rd_reg;
    logic [jbhd_pkg::ENTRY_W-1:0] ac_rd_reg;

    jbhd_pkg::state_t state_reg, state_next;
    jbhd_pkg::phase_t phase_reg, phase_next;

    logic [4:0]  dc_count_reg;
    logic [8:0]  ac_count_reg;
    logic [15:0] gcode_reg, gcode_next;
    logic [4:0]  glen_reg, glen_next;
    logic [3:0]  bits_rem_reg, bits_rem_next;
    logic [14:0] vbits_reg, vbits_next;
    logic [3:0]  mag_reg, mag_next;
    logic [6:0]  nidx_reg, nidx_next;
    logic [8:0]  scan_reg, scan_next;
    logic [6:0]  zeros_reg, zeros_next;
    logic        valp_reg, valp_next;
    logic [15:0] val_reg, val_next;
    logic        errp_reg, errp_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] coef_reg, coef_next;
    logic [5:0]  cidx_reg, cidx_next;
    logic        last_reg, last_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        slot_free;
    logic [8:0]  dc_n, ac_n, scan_n;
    logic [jbhd_pkg::ENTRY_W-1:0] entry;
    logic [16:0] len_mask;
    logic        hit;
    logic [15:0] vb_shift;
    logic [7:0]  hsym;
    logic [8:0]  scan_inc;

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == jbhd_pkg::ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign slot_free     = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign coefficient   = coef_reg;
    assign coeff_index   = cidx_reg;
    assign last_in_block = last_reg;
    assign error         = err_reg;

    assign dc_n   = ({4'd0, dc_count_reg} > DC_DEPTH_V) ? DC_DEPTH_V : {4'd0, dc_count_reg};
    assign ac_n   = (ac_count_reg > AC_DEPTH_V) ? AC_DEPTH_V : ac_count_reg;
    assign scan_n = (phase_reg == jbhd_pkg::PH_DC_CODE) ? dc_n : ac_n;
    assign entry  = (phase_reg == jbhd_pkg::PH_DC_CODE) ? dc_rd_reg : ac_rd_reg;
    assign len_mask = (17'd1 << glen_reg) - 17'd1;
    assign hit    = (entry[28:24] == glen_reg)
                    && (({1'b0, entry[23:8]} & len_mask) == {1'b0, gcode_reg});
    assign hsym   = entry[7:0];
    assign scan_inc = scan_reg + 9'd1;
    assign vb_shift = {vbits_reg, data_bit};

    // table memories
    always_ff @(posedge clk)
    begin
        if (accept && operation == jbhd_pkg::OP_LOAD_DC && {1'b0, entry_index} < DC_DEPTH_V)
        begin
            dc_mem[entry_index[DCAW-1:0]] <= {code_length, code_bits, symbol};
        end
        if (accept && operation == jbhd_pkg::OP_LOAD_AC && {1'b0, entry_index} < AC_DEPTH_V)
        begin
            ac_mem[entry_index[ACAW-1:0]] <= {code_length, code_bits, symbol};
        end
        dc_rd_reg <= dc_mem[scan_reg[DCAW-1:0]];
        ac_rd_reg <= ac_mem[scan_reg[ACAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_count_reg <= '0;
            ac_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == jbhd_pkg::REG_DC_COUNT)
                dc_count_reg <= cfg_data[4:0];
            else
                ac_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jbhd_pkg::ST_IDLE;
            phase_reg     <= jbhd_pkg::PH_DC_CODE;
            gcode_reg     <= '0;
            glen_reg      <= '0;
            bits_rem_reg  <= '0;
            vbits_reg     <= '0;
            mag_reg       <= '0;
            nidx_reg      <= '0;
            scan_reg      <= '0;
            zeros_reg     <= '0;
            valp_reg      <= 1'b0;
            errp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            gcode_reg     <= gcode_next;
            glen_reg      <= glen_next;
            bits_rem_reg  <= bits_rem_next;
            vbits_reg     <= vbits_next;
            mag_reg       <= mag_next;
            nidx_reg      <= nidx_next;
            scan_reg      <= scan_next;
            zeros_reg     <= zeros_next;
            valp_reg      <= valp_next;
            errp_reg      <= errp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        coef_reg <= coef_next;
        cidx_reg <= cidx_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        gcode_next     = gcode_reg;
        glen_next      = glen_reg;
        bits_rem_next  = bits_rem_reg;
        vbits_next     = vbits_reg;
        mag_next       = mag_reg;
        nidx_next      = nidx_reg;
        scan_next      = scan_reg;
        zeros_next     = zeros_reg;
        valp_next      = valp_reg;
        val_next       = val_reg;
        errp_next      = errp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        coef_next      = coef_reg;
        cidx_next      = cidx_reg;
        last_next      = last_reg;
        err_next       = err_reg;

        unique case (state_reg)
            jbhd_pkg::ST_IDLE:
            begin
                if (accept && operation == jbhd_pkg::OP_DATA)
                begin
                    if (phase_reg == jbhd_pkg::PH_DC_BITS || phase_reg == jbhd_pkg::PH_AC_BITS)
                    begin
                        vbits_next    = vb_shift[14:0];
                        bits_rem_next = bits_rem_reg - 4'd1;
                        if (bits_rem_reg == 4'd1)
                        begin
                            if (phase_reg == jbhd_pkg::PH_DC_BITS)
                                zeros_next = '0;
                            phase_next = jbhd_pkg::PH_AC_CODE;
                            val_next   = jbhd_pkg::mag_to_value(mag_reg, vb_shift[14:0]);
                            valp_next  = 1'b1;
                            vbits_next = '0;
                            state_next = jbhd_pkg::ST_EMIT;
                        end
                    end
                    else
                    begin
                        gcode_next = {gcode_reg[14:0], data_bit};
                        glen_next  = glen_reg + 5'd1;
                        scan_next  = '0;
                        state_next = jbhd_pkg::ST_READ;
                    end
                end
            end

            jbhd_pkg::ST_READ:
            begin
                if (scan_reg >= scan_n)
                begin
                    if (glen_reg >= MAX_LEN)
                    begin
                        errp_next  = 1'b1;
                        state_next = jbhd_pkg::ST_EMIT;
                    end
                    else
                        state_next = jbhd_pkg::ST_IDLE;
                end
                else
                    state_next = jbhd_pkg::ST_CMP;
            end

            jbhd_pkg::ST_CMP:
            begin
                if (!hit)
                begin
                    scan_next  = scan_inc;
                    state_next = jbhd_pkg::ST_READ;
                end
                else
                begin
                    gcode_next = '0;
                    glen_next  = '0;
                    vbits_next = '0;
                    if (phase_reg == jbhd_pkg::PH_DC_CODE)
                    begin
                        if (hsym > jbhd_pkg::MAG_MAX)
                        begin
                            errp_next  = 1'b1;
                            state_next = jbhd_pkg::ST_EMIT;
                        end
                        else if (hsym == jbhd_pkg::SYM_EOB)
                        begin
                            mag_next   = '0;
                            phase_next = jbhd_pkg::PH_AC_CODE;
                            zeros_next = '0;
                            val_next   = '0;
                            valp_next  = 1'b1;
                            state_next = jbhd_pkg::ST_EMIT;
                        end
                        else
                        begin
                            mag_next      = hsym[3:0];
                            bits_rem_next = hsym[3:0];
                            phase_next    = jbhd_pkg::PH_DC_BITS;
                            state_next    = jbhd_pkg::ST_IDLE;
                        end
                    end
                    else if (hsym == jbhd_pkg::SYM_EOB)
                    begin
                        zeros_next = 7'(BLOCK_COEFFS);
                        valp_next  = 1'b0;
                        state_next = jbhd_pkg::ST_EMIT;
                    end
                    else
                    begin
                        zeros_next = {3'd0, hsym[7:4]};
                        mag_next   = hsym[3:0];
                        if (hsym[3:0] == 4'd0)
                        begin
                            val_next   = '0;
                            valp_next  = 1'b1;
                            state_next = jbhd_pkg::ST_EMIT;
                        end
                        else
                        begin
                            bits_rem_next = hsym[3:0];
                            phase_next    = jbhd_pkg::PH_AC_BITS;
                            state_next    = jbhd_pkg::ST_IDLE;
                        end
                    end
                end
            end

            jbhd_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    cidx_next      = nidx_reg[5:0];
                    if (errp_reg)
                    begin
                        coef_next = '0;
                        last_next = 1'b1;
                        err_next  = 1'b1;
                        errp_next = 1'b0;
                        zeros_next = '0;
                        valp_next = 1'b0;
                    end
                    else
                    begin
                        err_next  = 1'b0;
                        last_next = (nidx_reg == LAST_IDX);
                        if (zeros_reg != 7'd0)
                        begin
                            coef_next  = '0;
                            zeros_next = zeros_reg - 7'd1;
                        end
                        else
                        begin
                            coef_next = val_reg;
                            valp_next = 1'b0;
                        end
                        nidx_next = nidx_reg + 7'd1;
                    end
                    if (errp_reg || nidx_reg == LAST_IDX)
                    begin
                        // rearm for a new block
                        phase_next    = jbhd_pkg::PH_DC_CODE;
                        gcode_next    = '0;
                        glen_next     = '0;
                        bits_rem_next = '0;
                        vbits_next    = '0;
                        mag_next      = '0;
                        nidx_next     = '0;
                        zeros_next    = '0;
                        valp_next     = 1'b0;
                        state_next    = jbhd_pkg::ST_IDLE;
                    end
                    else if ((zeros_reg == 7'd0) || (zeros_reg == 7'd1 && !valp_reg))
                        state_next = jbhd_pkg::ST_IDLE;
                end
            end

            default:
                state_next = jbhd_pkg::ST_IDLE;
        endcase
    end

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last_in_block)
        else $error("error result without last_in_block");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error && last_in_block |-> coeff_index == LAST_IDX[5:0])
        else $error("last_in_block on a coefficient that does not close the block");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        nidx_reg <= LAST_IDX)
        else $error("coefficient position ran past the block");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coeff_index) && $stable(coefficient))
        else $error("stalled result was overwritten");

endmodule

@@ test/jpeg_block_huffman_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_block_huffman_decoder_tb
// self-checking testbench for the baseline jpeg block coefficient decoder
// ----------------------------------------------------------------------------
// A short directed table covers these cases:
//   - a stream with empty tables that runs into the no-match error
//   - the unused operation and a load to a slot out of range
//   - a dc symbol above 15, a zero dc magnitude and the zero run of sixteen
//   - end of block
// Random phases then load fresh tables, change the entry counts while the
// block is idle, and feed mostly well-formed code and magnitude streams with
// some noise mixed in. A predictor in the testbench computes the expected
// coefficients. Both channels idle at random, with one quiet window and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module jpeg_block_huffman_decoder_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 600;
    localparam int QUIET_LO    = 4000;
    localparam int QUIET_HI    = 9000;
    localparam int N_PHASES    = 5;
    localparam int STREAM_LEN  = 42;
    localparam int DC_DEPTH    = jbhd_pkg::DC_TABLE_DEPTH_DEF;
    localparam int AC_DEPTH    = jbhd_pkg::AC_TABLE_DEPTH_DEF;
    localparam int BLK         = jbhd_pkg::BLOCK_COEFFS_DEF;
    localparam int MAX_BITS    = jbhd_pkg::MAX_CODE_BITS_DEF;

    typedef struct {
        logic [4:0]  len;
        logic [15:0] code;
        logic [7:0]  sym;
    } entry_t;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [4:0]  len;
        logic [15:0] code;
        logic [7:0]  sym;
        logic        bit_in;
    } item_t;

    typedef struct {
        logic signed [15:0] coef;
        logic [5:0]         pos;
        logic               last;
        logic               err;
    } coeff_t;

    typedef struct {
        item_t  it;
        logic   chk;
        coeff_t res;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [8:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic [7:0]         entry_index;
    logic [4:0]         code_length;
    logic [15:0]        code_bits;
    logic [7:0]         symbol;
    logic               data_bit;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] coefficient;
    logic [5:0]         coeff_index;
    logic               last_in_block;
    logic               error;

    jpeg_block_huffman_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .entry_index  (entry_index),
        .code_length  (code_length),
        .code_bits    (code_bits),
        .symbol       (symbol),
        .data_bit     (data_bit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coefficient  (coefficient),
        .coeff_index  (coeff_index),
        .last_in_block(last_in_block),
        .error        (error)
    );

    // predictor state
    entry_t           dc_tab [DC_DEPTH];
    entry_t           ac_tab [AC_DEPTH];
    int               dc_count;
    int               ac_count;
    logic [15:0]      gcode;
    int               glen;
    jbhd_pkg::phase_t phase;
    int               brem;
    logic [14:0]      vbits;
    int               cmag;
    int               prun;
    int               nidx;

    coeff_t      expected_coeffs [$];
    logic        stream_bits [$];
    row_t        dir_rows [30];

    int          cycle;
    int          mismatches;
    int          n_items;
    int          n_coeffs;
    int          n_errs;
    int          n_eob_blocks;
    int          hold_left;
    logic        hold_done;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic quiet();
        return cycle >= QUIET_LO && cycle < QUIET_HI;
    endfunction

    task automatic rearm();
        gcode = '0;
        glen  = 0;
        phase = jbhd_pkg::PH_DC_CODE;
        brem  = 0;
        vbits = '0;
        cmag  = 0;
        prun  = 0;
        nidx  = 0;
    endtask

    task automatic push_coeff(int c, int pos, logic last, logic err);
        coeff_t r;
        r.coef = c[15:0];
        r.pos  = pos[5:0];
        r.last = last;
        r.err  = err;
        expected_coeffs.push_back(r);
    endtask

    task automatic emit(int c);
        if (nidx < BLK)
        begin
            push_coeff(c, nidx, nidx == BLK - 1, 1'b0);
            nidx++;
            if (nidx >= BLK)
                rearm();
        end
    endtask

    task automatic fail_block();
        push_coeff(0, (nidx >= BLK) ? BLK - 1 : nidx, 1'b1, 1'b1);
        rearm();
    endtask

    function automatic int signed_value(int m, logic [14:0] vb);
        int v;
        if (m == 0 || m > 15)
            return 0;
        v = int'(vb) & ((1 << m) - 1);
        if ((v >> (m - 1)) & 1)
            return v;
        return v - ((1 << m) - 1);
    endfunction

    task automatic emit_run_value(int c);
        int run;
        run = prun;
        for (int r = 0; r < run; r++)
        begin
            emit(0);
            if (phase == jbhd_pkg::PH_DC_CODE)
                return;
        end
        emit(c);
        if (phase != jbhd_pkg::PH_DC_CODE)
            phase = jbhd_pkg::PH_AC_CODE;
        prun = 0;
    endtask

    function automatic int find_entry(logic use_ac);
        int n;
        entry_t e;
        n = use_ac ? ((ac_count > AC_DEPTH) ? AC_DEPTH : ac_count)
                   : ((dc_count > DC_DEPTH) ? DC_DEPTH : dc_count);
        for (int i = 0; i < n; i++)
        begin
            e = use_ac ? ac_tab[i] : dc_tab[i];
            if (int'(e.len) == glen && ((int'(e.code) & ((1 << glen) - 1)) == int'(gcode)))
                return i;
        end
        return -1;
    endfunction

    task automatic decode_bit(logic b);
        int hit;
        int sym;
        if (phase == jbhd_pkg::PH_DC_BITS || phase == jbhd_pkg::PH_AC_BITS)
        begin
            vbits = {vbits[13:0], b};
            if (brem > 0)
                brem--;
            if (brem != 0)
                return;
            if (phase == jbhd_pkg::PH_DC_BITS)
                prun = 0;
            phase = jbhd_pkg::PH_AC_CODE;
            emit_run_value(signed_value(cmag, vbits));
            vbits = '0;
            return;
        end
        gcode = {gcode[14:0], b};
        glen++;
        hit = find_entry(phase == jbhd_pkg::PH_AC_CODE);
        if (hit < 0)
        begin
            if (glen >= MAX_BITS)
            begin
                n_errs++;
                fail_block();
            end
            return;
        end
        gcode = '0;
        glen  = 0;
        vbits = '0;
        if (phase == jbhd_pkg::PH_DC_CODE)
        begin
            sym = dc_tab[hit].sym;
            if (sym > jbhd_pkg::MAG_MAX)
            begin
                n_errs++;
                fail_block();
                return;
            end
            prun = 0;
            cmag = sym;
            if (sym == 0)
            begin
                phase = jbhd_pkg::PH_AC_CODE;
                emit(0);
                return;
            end
            brem  = sym;
            phase = jbhd_pkg::PH_DC_BITS;
            return;
        end
        sym = ac_tab[hit].sym;
        if (sym == jbhd_pkg::SYM_EOB)
        begin
            n_eob_blocks++;
            while (phase != jbhd_pkg::PH_DC_CODE)
                emit(0);
            return;
        end
        prun = (sym >> 4) & 15;
        cmag = sym & 15;
        if (cmag == 0)
        begin
            emit_run_value(0);
            return;
        end
        brem  = cmag;
        phase = jbhd_pkg::PH_AC_BITS;
    endtask

    task automatic decode_item(item_t it);
        entry_t e;
        e.len  = it.len;
        e.code = it.code;
        e.sym  = it.sym;
        case (it.op)
            jbhd_pkg::OP_LOAD_DC: if (it.idx < DC_DEPTH) dc_tab[it.idx] = e;
            jbhd_pkg::OP_LOAD_AC: ac_tab[it.idx] = e;
            jbhd_pkg::OP_DATA:    decode_bit(it.bit_in);
            default:    ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle, what);
        mismatches++;
    endtask

    // called at a falling edge, returns at a falling edge after the transaction
    task automatic send_item(item_t it, logic chk, coeff_t res);
        int before_sz;
        while (!quiet() && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        before_sz = expected_coeffs.size();
        decode_item(it);
        if (chk)
        begin
            while (expected_coeffs.size() > before_sz)
                void'(expected_coeffs.pop_back());
            expected_coeffs.push_back(res);
        end
        in_valid    <= 1'b1;
        operation   <= it.op;
        entry_index <= it.idx;
        code_length <= it.len;
        code_bits   <= it.code;
        symbol      <= it.sym;
        data_bit    <= it.bit_in;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_items++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_counts(int dc, int ac);
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_coeffs.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        write_reg(jbhd_pkg::REG_DC_COUNT, dc[8:0]);
        write_reg(jbhd_pkg::REG_AC_COUNT, ac[8:0]);
        dc_count = dc & 'h1F;
        ac_count = ac & 'h1FF;
    endtask

    function automatic item_t mk_item(logic [1:0] op, int idx, int len, int code, int sym,
                                      logic b);
        item_t it;
        it.op     = op;
        it.idx    = idx[7:0];
        it.len    = len[4:0];
        it.code   = code[15:0];
        it.sym    = sym[7:0];
        it.bit_in = b;
        return it;
    endfunction

    function automatic item_t rand_load(logic use_ac, int slot);
        int len;
        int sym;
        len = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 0
                                              : $urandom_range(17, 31))
                                          : $urandom_range(1, MAX_BITS);
        if (use_ac)
        begin
            case ($urandom_range(0, 19))
                0, 1:    sym = jbhd_pkg::SYM_EOB;
                2:       sym = 'hF0;
                default: sym = $urandom_range(0, 255);
            endcase
        end
        else
            sym = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
        return mk_item(use_ac ? jbhd_pkg::OP_LOAD_AC : jbhd_pkg::OP_LOAD_DC, slot, len,
                       $urandom(), sym, 1'b0);
    endfunction

    task automatic refill_stream();
        int n;
        int s;
        entry_t e;
        if ($urandom_range(0, 99) < 8)
        begin
            stream_bits.push_back($urandom_range(0, 1));
            return;
        end
        if (phase == jbhd_pkg::PH_DC_BITS || phase == jbhd_pkg::PH_AC_BITS)
        begin
            for (int i = 0; i < brem; i++)
                stream_bits.push_back($urandom_range(0, 1));
            return;
        end
        if (phase == jbhd_pkg::PH_AC_CODE)
            n = (ac_count > AC_DEPTH) ? AC_DEPTH : ac_count;
        else
            n = (dc_count > DC_DEPTH) ? DC_DEPTH : dc_count;
        if (n == 0)
        begin
            stream_bits.push_back($urandom_range(0, 1));
            return;
        end
        s = $urandom_range(0, n - 1);
        e = (phase == jbhd_pkg::PH_AC_CODE) ? ac_tab[s] : dc_tab[s];
        if (e.len == 0 || e.len > MAX_BITS)
            stream_bits.push_back($urandom_range(0, 1));
        else
            for (int i = int'(e.len) - 1; i >= 0; i--)
                stream_bits.push_back(e.code[i]);
    endtask

    // receiver: random stalls, one long hold-off while items keep coming
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && n_coeffs >= 150 && in_valid)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= quiet() ? 1'b1 : ($urandom_range(0, 99) >= 35);
    end

    // coefficient checker
    always @(posedge clk)
    begin
        coeff_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_coeffs++;
            if (expected_coeffs.size() == 0)
                report_mismatch($sformatf("unexpected coefficient at index %0d", coeff_index));
            else
            begin
                e = expected_coeffs.pop_front();
                if (coefficient !== e.coef)
                    report_mismatch($sformatf("coefficient %0d, expected %0d",
                                              coefficient, e.coef));
                if (coeff_index !== e.pos)
                    report_mismatch($sformatf("coeff_index %0d, expected %0d",
                                              coeff_index, e.pos));
                if (last_in_block !== e.last)
                    report_mismatch($sformatf("last_in_block %0b, expected %0b at index %0d",
                                              last_in_block, e.last, e.pos));
                if (error !== e.err)
                    report_mismatch($sformatf("error %0b, expected %0b at index %0d",
                                              error, e.err, e.pos));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("timeout with %0d coefficients outstanding", expected_coeffs.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        coeff_t none;
        coeff_t err_res;
        int dc_n;
        int ac_n;
        int dc_w;
        int ac_w;
        item_t it;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        operation   = jbhd_pkg::OP_NONE;
        entry_index = '0;
        code_length = '0;
        code_bits   = '0;
        symbol      = '0;
        data_bit    = 1'b0;
        cycle       = 0;
        mismatches  = 0;
        n_items     = 0;
        n_coeffs    = 0;
        n_errs      = 0;
        n_eob_blocks = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        dc_count    = 0;
        ac_count    = 0;
        none        = '{coef: 16'sd0, pos: 6'd0, last: 1'b0, err: 1'b0};
        err_res     = '{coef: 16'sd0, pos: 6'd0, last: 1'b1, err: 1'b1};
        for (int i = 0; i < DC_DEPTH; i++)
            dc_tab[i] = '{len: '0, code: '0, sym: '0};
        for (int i = 0; i < AC_DEPTH; i++)
            ac_tab[i] = '{len: '0, code: '0, sym: '0};
        rearm();

        // directed table
        for (int i = 0; i < 16; i++)
            dir_rows[i] = '{it: mk_item(jbhd_pkg::OP_DATA, 0, 0, 0, 0, i[0]), chk: 1'b0,
                            res: none};
        dir_rows[15].chk = 1'b1;
        dir_rows[15].res = err_res;
        dir_rows[16] = '{it: mk_item(jbhd_pkg::OP_NONE, 'hFF, 31, 'hFFFF, 'hFF, 1'b1),
                         chk: 1'b0, res: none};
        dir_rows[17] = '{it: mk_item(jbhd_pkg::OP_LOAD_DC, 20, 1, 0, 0, 1'b0), chk: 1'b0,
                         res: none};
        dir_rows[18] = '{it: mk_item(jbhd_pkg::OP_LOAD_DC, 0, 2, 'b10, 'h1F, 1'b0), chk: 1'b0,
                         res: none};
        dir_rows[19] = '{it: mk_item(jbhd_pkg::OP_LOAD_DC, 1, 1, 0, 0, 1'b0), chk: 1'b0,
                         res: none};
        dir_rows[20] = '{it: mk_item(jbhd_pkg::OP_LOAD_AC, 0, 0, 0, 'h11, 1'b0), chk: 1'b0,
                         res: none};
        dir_rows[21] = '{it: mk_item(jbhd_pkg::OP_LOAD_AC, 1, 2, 'hFFFF, jbhd_pkg::SYM_EOB,
                                     1'b0), chk: 1'b0, res: none};
        dir_rows[22] = '{it: mk_item(jbhd_pkg::OP_LOAD_AC, 2, 1, 0, 'hF0, 1'b0), chk: 1'b0,
                         res: none};
        dir_rows[23] = '{it: mk_item(jbhd_pkg::OP_LOAD_AC, 3, 16, 'hFFFF, 'h0F, 1'b0),
                         chk: 1'b0, res: none};
        dir_rows[24] = '{it: mk_item(jbhd_pkg::OP_DATA, 0, 0, 0, 0, 1'b1), chk: 1'b0,
                         res: none};
        dir_rows[25] = '{it: mk_item(jbhd_pkg::OP_DATA, 0, 0, 0, 0, 1'b0), chk: 1'b1,
                         res: err_res};
        dir_rows[26] = '{it: mk_item(jbhd_pkg::OP_DATA, 0, 0, 0, 0, 1'b0), chk: 1'b1,
                         res: none};
        dir_rows[27] = '{it: mk_item(jbhd_pkg::OP_DATA, 0, 0, 0, 0, 1'b0), chk: 1'b0,
                         res: none};
        dir_rows[28] = '{it: mk_item(jbhd_pkg::OP_DATA, 0, 0, 0, 0, 1'b1), chk: 1'b0,
                         res: none};
        dir_rows[29] = '{it: mk_item(jbhd_pkg::OP_DATA, 0, 0, 0, 0, 1'b1), chk: 1'b0,
                         res: none};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 30; i++)
        begin
            if (i == 24)
                write_counts(2, 4);
            send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].res);
        end

        // random phases: load tables, set counts, stream bits
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            dc_n = (ph == 3) ? DC_DEPTH : $urandom_range(1, DC_DEPTH);
            ac_n = (ph == 3) ? 32 : $urandom_range(1, 16);
            for (int s = 0; s < dc_n; s++)
            begin
                send_item(rand_load(1'b0, s), 1'b0, none);
                if ($urandom_range(0, 19) == 0)
                    send_item(rand_load(1'b0, $urandom_range(DC_DEPTH, 255)),
                              1'b0, none);
            end
            for (int s = 0; s < ac_n; s++)
                send_item(rand_load(1'b1, s), 1'b0, none);
            dc_w = dc_n;
            ac_w = ac_n;
            if (ph == N_PHASES - 1 || (dc_n == DC_DEPTH && $urandom_range(0, 1) == 1))
                dc_w = 31;
            write_counts(dc_w, ac_w);
            stream_bits.delete();
            for (int k = 0; k < STREAM_LEN; k++)
            begin
                if (stream_bits.size() == 0)
                    refill_stream();
                it = mk_item(jbhd_pkg::OP_DATA, $urandom_range(0, 255), $urandom_range(0, 31),
                             $urandom(), $urandom_range(0, 255), stream_bits.pop_front());
                if ($urandom_range(0, 49) == 0)
                    it.op = jbhd_pkg::OP_NONE;
                send_item(it, 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_coeffs.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("%0d items sent, %0d coefficients checked", n_items, n_coeffs);
        $display("%0d error results, %0d end-of-block codes, %0d mismatches",
                 n_errs, n_eob_blocks, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/jbhd_pkg.sv
hw/rtl/jpeg_block_huffman_decoder.sv
test/jpeg_block_huffman_decoder_tb.sv
